// ----- rtl/tblf_pkg.sv -----
// Package for the thumbnail block line filter.
// Holds sizes, character codes, marker tables, state and select encodings,
// and the command and status structs shared by the controller and datapath.
package tblf_pkg;

    localparam int PREFIX_DEPTH = 32;
    localparam int MATCH_WINDOW = (PREFIX_DEPTH < 35) ? PREFIX_DEPTH : 35;
    localparam int ADDR_W       = $clog2(PREFIX_DEPTH);
    localparam int CNT_W        = $clog2(MATCH_WINDOW + 1);
    localparam int NPAT         = 6;
    localparam int KIND_MAX     = 19;
    localparam int HEAD_LEN     = 5;

    localparam logic [NPAT-1:0] ALL_ALIVE = '1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_M     = 8'h4D;

    // Entries 0..2 are begin markers, 3..5 are end markers.
    localparam int unsigned KIND_LEN [NPAT] = '{15, 19, 9, 13, 17, 7};

    typedef enum logic [6:0] {
        PH_START   = 7'b0000001,
        PH_COMMENT = 7'b0000010,
        PH_HEAD    = 7'b0000100,
        PH_WS      = 7'b0001000,
        PH_KIND    = 7'b0010000,
        PH_PASS    = 7'b0100000,
        PH_DROP    = 7'b1000000
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LEAD = 5'b00010,
        S_RD   = 5'b00100,
        S_BUF  = 5'b01000,
        S_LF   = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_NEW,
        SEL_LEAD,
        SEL_BUF,
        SEL_LF
    } t_sel;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        t_sel load_sel;
        logic load_last;
    } t_cmd;

    typedef struct packed {
        logic new_lead;
        logic new_flush;
        logic new_lf;
        logic lead_en;
        logic flush_en;
        logic lf_en;
        logic rd_done;
        logic out_free;
        logic stopped;
        logic in_block;
    } t_status;

    function automatic logic [KIND_MAX*8-1:0] kind_str(input int unsigned idx);
        logic [KIND_MAX*8-1:0] s;
        s = '0;
        case (idx)
            0:       s = "thumbnail begin";
            1:       s = {"thumbnail", "_JPG begin"};
            2:       s = "jpg begin";
            3:       s = "thumbnail end";
            4:       s = {"thumbnail", "_JPG end"};
            5:       s = "jpg end";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] pat_char(input int unsigned idx, input int unsigned pos);
        logic [KIND_MAX*8-1:0] s;
        int unsigned           len;
        logic [7:0]            ch;
        s   = kind_str(idx);
        len = KIND_LEN[idx];
        ch  = 8'h00;
        if (pos < len) begin
            ch = s[(len - 1 - pos)*8 +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] head_char(input logic [2:0] k);
        logic [7:0] ch;
        case (k)
            3'd0:    ch = "M";
            3'd1:    ch = "4";
            3'd2:    ch = "0";
            3'd3:    ch = "1";
            3'd4:    ch = "0";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/thumbnail_block_line_filter.sv -----
// Top level of the thumbnail block line filter: controller plus datapath.
// Depends on tblf_pkg, tblf_ctrl, tblf_dp (and tblf_ram through tblf_dp).
//
//   channel   | dir | tdata        | tlast
//   ----------+-----+--------------+------------------------------------
//   s_axis    | in  | [7:0] byte   | end of file
//   m_axis    | out | [7:0] byte   | last result byte of one input byte
//
// A byte with no result, or only a leading data byte and a free output, is
// done in the cycle it is accepted; a byte whose only result is LF is accepted,
// then LF is loaded. A marker flush starts the prefix RAM read, then loads one
// byte per cycle while the output is free (single RAM read port), then any LF.
// Reset is synchronous; it clears line state, not the prefix RAM contents.
// Output stalls hold the output register; input is held off until all result
// bytes of the current transfer are loaded.
module thumbnail_block_line_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);
    import tblf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tblf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    tblf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_byte      (i_s_axis_tdata),
        .i_eof       (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_byte  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

`ifndef SYNTH
    a_stopped_not_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.stopped |-> !w_status.in_block)
        else $error("in-block flag set while file is stopped");

    a_run_pending_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |-> !o_s_axis_tready)
        else $error("input ready while result run is incomplete");

    a_stopped_no_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && w_status.stopped) |=> o_s_axis_tready)
        else $error("stopped file produced results");
`endif

endmodule

// ----- rtl/tblf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
module tblf_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tblf_ctrl.sv -----
// Controller of the thumbnail block line filter: sequences one input
// transfer and its result bytes. Depends on tblf_pkg.
module tblf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tblf_pkg::t_status i_status,
    output tblf_pkg::t_cmd    o_cmd
);
    import tblf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.accept    = 1'b0;
        o_cmd.rd_issue  = 1'b0;
        o_cmd.load_sel  = SEL_NONE;
        o_cmd.load_last = 1'b0;
        o_ready         = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.new_lead) begin
                        if (i_status.out_free) begin
                            o_cmd.load_sel  = SEL_NEW;
                            o_cmd.load_last = !i_status.new_flush && !i_status.new_lf;
                            if (i_status.new_flush) begin
                                n_state = S_RD;
                            end else if (i_status.new_lf) begin
                                n_state = S_LF;
                            end
                        end else begin
                            n_state = S_LEAD;
                        end
                    end else if (i_status.new_flush) begin
                        n_state = S_RD;
                    end else if (i_status.new_lf) begin
                        n_state = S_LF;
                    end
                end
            end
            S_LEAD: begin
                if (i_status.out_free) begin
                    o_cmd.load_sel  = SEL_LEAD;
                    o_cmd.load_last = !i_status.flush_en && !i_status.lf_en;
                    if (i_status.flush_en) begin
                        n_state = S_RD;
                    end else if (i_status.lf_en) begin
                        n_state = S_LF;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_BUF;
            end
            S_BUF: begin
                if (i_status.out_free) begin
                    o_cmd.load_sel  = SEL_BUF;
                    o_cmd.load_last = i_status.rd_done && !i_status.lf_en;
                    if (!i_status.rd_done) begin
                        o_cmd.rd_issue = 1'b1;
                    end else if (i_status.lf_en) begin
                        n_state = S_LF;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LF: begin
                if (i_status.out_free) begin
                    o_cmd.load_sel  = SEL_LF;
                    o_cmd.load_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/tblf_dp.sv -----
// Datapath of the thumbnail block line filter: line state, marker matching,
// prefix buffer, result plan and output register. Depends on tblf_pkg, tblf_ram.
module tblf_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tblf_pkg::t_cmd    i_cmd,
    output tblf_pkg::t_status o_status,
    input  logic [7:0]        i_byte,
    input  logic              i_eof,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last
);
    import tblf_pkg::*;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] n_pos;
    logic [NPAT-1:0]  r_alive;
    logic [NPAT-1:0]  n_alive;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_in_block;
    logic             n_in_block;
    logic             r_stopped;
    logic             n_stopped;

    logic             r_lead_en;
    logic [7:0]       r_lead_byte;
    logic             r_flush_en;
    logic [CNT_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_rd_end;
    logic             r_lf_en;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             term;
    logic             is_blank;
    t_phase           e_ph;
    logic             streaming;
    logic             mt_comment;
    logic [CNT_W-1:0] mt_pos;
    logic [NPAT-1:0]  mt_alive;
    logic [CNT_W:0]   m_len [NPAT];
    logic [7:0]       m_ch [NPAT];
    logic [NPAT-1:0]  m_alive;
    logic [NPAT-1:0]  m_done;
    logic             m_begin;
    logic             m_end;
    logic [CNT_W-1:0] cnt_inc;

    logic             p_lead;
    logic [7:0]       p_lead_byte;
    logic             p_flush;
    logic [CNT_W-1:0] p_lo;
    logic             p_lf;
    logic             ram_we;
    logic [7:0]       ram_q;
    logic             out_free;

    tblf_ram #(
        .WIDTH (8),
        .DEPTH (PREFIX_DEPTH)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && ram_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (i_byte),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd_ptr[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    assign cnt_inc  = CNT_W'(r_cnt + 1'b1);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        term     = (i_byte == CH_CR) || (i_byte == CH_LF) || (i_byte == CH_NUL);
        is_blank = (i_byte == CH_SPACE) || (i_byte == CH_TAB);
        e_ph     = r_phase;
        if (r_phase == PH_START) begin
            if (i_byte == CH_SEMI) begin
                e_ph = PH_COMMENT;
            end else if (i_byte == CH_M) begin
                e_ph = PH_HEAD;
            end else begin
                e_ph = PH_DROP;
            end
        end
        streaming  = ((e_ph == PH_WS) || (e_ph == PH_KIND)) && r_in_block;
        mt_comment = (e_ph == PH_COMMENT);
        if (e_ph == PH_WS) begin
            mt_pos   = '0;
            mt_alive = ALL_ALIVE;
        end else begin
            mt_pos   = r_pos;
            mt_alive = r_alive;
        end
    end

    always_comb begin
        for (int i = 0; i < NPAT; i++) begin
            m_len[i] = (CNT_W+1)'(KIND_LEN[i]) + (mt_comment ? (CNT_W+1)'(2) : '0);
            if (!mt_comment) begin
                m_ch[i] = pat_char(i, int'(mt_pos));
            end else if (mt_pos == '0) begin
                m_ch[i] = CH_SEMI;
            end else if (mt_pos == CNT_W'(1)) begin
                m_ch[i] = CH_SPACE;
            end else begin
                m_ch[i] = pat_char(i, int'(mt_pos) - 2);
            end
            m_alive[i] = mt_alive[i] && ({1'b0, mt_pos} < m_len[i]) && (m_ch[i] == i_byte);
            m_done[i]  = m_alive[i] && (m_len[i] == ({1'b0, mt_pos} + 1'b1));
        end
        m_begin = |m_done[2:0];
        m_end   = |m_done[NPAT-1:3];
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_alive     = r_alive;
        n_cnt       = r_cnt;
        n_in_block  = r_in_block;
        n_stopped   = r_stopped;
        p_lead      = 1'b0;
        p_lead_byte = i_byte;
        p_flush     = 1'b0;
        p_lo        = '0;
        p_lf        = 1'b0;
        ram_we      = 1'b0;
        if (r_stopped) begin
            if (i_eof) begin
                n_phase    = PH_START;
                n_pos      = '0;
                n_alive    = ALL_ALIVE;
                n_cnt      = '0;
                n_in_block = 1'b0;
                n_stopped  = 1'b0;
            end
        end else begin
            if (term) begin
                p_lf = (r_phase == PH_PASS) ||
                       (((r_phase == PH_WS) || (r_phase == PH_KIND)) && r_in_block);
                n_phase = PH_START;
                n_pos   = '0;
                n_alive = ALL_ALIVE;
                n_cnt   = '0;
            end else begin
                unique case (e_ph)
                    PH_PASS: begin
                        p_lead = 1'b1;
                    end
                    PH_DROP: begin
                        n_phase = PH_DROP;
                    end
                    default: begin
                        p_lead = streaming;
                        if (r_cnt >= CNT_W'(MATCH_WINDOW)) begin
                            n_phase = streaming ? PH_PASS : PH_DROP;
                        end else begin
                            ram_we  = 1'b1;
                            n_cnt   = cnt_inc;
                            n_phase = e_ph;
                            if (e_ph == PH_COMMENT) begin
                                n_pos   = CNT_W'(r_pos + 1'b1);
                                n_alive = m_alive;
                                if (m_begin || m_end) begin
                                    p_flush    = 1'b1;
                                    n_in_block = m_begin;
                                    n_phase    = PH_PASS;
                                end else if (m_alive == '0) begin
                                    n_phase = PH_DROP;
                                end
                            end else if (e_ph == PH_HEAD) begin
                                if ((r_cnt >= CNT_W'(HEAD_LEN)) ||
                                    (head_char(r_cnt[2:0]) != i_byte)) begin
                                    n_phase = PH_DROP;
                                end else if (r_cnt == CNT_W'(HEAD_LEN - 1)) begin
                                    p_lead      = r_in_block;
                                    p_lead_byte = CH_SEMI;
                                    n_phase     = PH_WS;
                                end
                            end else if (!((e_ph == PH_WS) && is_blank)) begin
                                n_phase = PH_KIND;
                                n_pos   = CNT_W'(mt_pos + 1'b1);
                                n_alive = m_alive;
                                if (m_begin || m_end) begin
                                    if (!streaming) begin
                                        p_lead      = 1'b1;
                                        p_lead_byte = CH_SEMI;
                                        p_flush     = 1'b1;
                                        p_lo        = CNT_W'(HEAD_LEN);
                                    end
                                    n_in_block = m_begin;
                                    n_phase    = PH_PASS;
                                end else if (m_alive == '0) begin
                                    n_phase = streaming ? PH_PASS : PH_DROP;
                                end
                            end
                        end
                    end
                endcase
                if (i_eof) begin
                    p_lf = (n_phase == PH_PASS) ||
                           (((n_phase == PH_WS) || (n_phase == PH_KIND)) && n_in_block);
                end
            end
            if ((i_byte == CH_NUL) || i_eof) begin
                n_phase    = PH_START;
                n_pos      = '0;
                n_alive    = ALL_ALIVE;
                n_cnt      = '0;
                n_in_block = 1'b0;
                n_stopped  = (i_byte == CH_NUL) && !i_eof;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_pos      <= '0;
            r_alive    <= ALL_ALIVE;
            r_cnt      <= '0;
            r_in_block <= 1'b0;
            r_stopped  <= 1'b0;
            r_lead_en  <= 1'b0;
            r_flush_en <= 1'b0;
            r_lf_en    <= 1'b0;
        end else if (i_cmd.accept) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_alive    <= n_alive;
            r_cnt      <= n_cnt;
            r_in_block <= n_in_block;
            r_stopped  <= n_stopped;
            r_lead_en  <= p_lead;
            r_flush_en <= p_flush;
            r_lf_en    <= p_lf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lead_byte <= p_lead_byte;
            r_rd_ptr    <= p_lo;
            r_rd_end    <= cnt_inc;
        end else if (i_cmd.rd_issue) begin
            r_rd_ptr <= CNT_W'(r_rd_ptr + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_sel != SEL_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.load_sel)
            SEL_NEW: begin
                r_out_byte <= p_lead_byte;
                r_out_last <= i_cmd.load_last;
            end
            SEL_LEAD: begin
                r_out_byte <= r_lead_byte;
                r_out_last <= i_cmd.load_last;
            end
            SEL_BUF: begin
                r_out_byte <= ram_q;
                r_out_last <= i_cmd.load_last;
            end
            SEL_LF: begin
                r_out_byte <= CH_LF;
                r_out_last <= i_cmd.load_last;
            end
            default: begin
                r_out_byte <= r_out_byte;
                r_out_last <= r_out_last;
            end
        endcase
    end

    always_comb begin
        o_status.new_lead  = p_lead;
        o_status.new_flush = p_flush;
        o_status.new_lf    = p_lf;
        o_status.lead_en   = r_lead_en;
        o_status.flush_en  = r_flush_en;
        o_status.lf_en     = r_lf_en;
        o_status.rd_done   = (r_rd_ptr == r_rd_end);
        o_status.out_free  = out_free;
        o_status.stopped   = r_stopped;
        o_status.in_block  = r_in_block;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule
